// ===== design/pkcsu_pkg.sv =====
// ----------------------------------------------------------------------------
// pkcsu_pkg: shared types and constants for the block unpadder
// Phase codes, status codes, register indexes and the state and result
// structs passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package pkcsu_pkg;

  // Parse phase within one block
  typedef enum logic [2:0] {
    PhFirst = 3'd0,
    PhType  = 3'd1,
    PhPad   = 3'd2,
    PhData  = 3'd3,
    PhDrain = 3'd4
  } phase_e;

  // Status reported with the last byte
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadType  = 3'd2,
    StNoSep    = 3'd3,
    StShortPad = 3'd4
  } status_e;

  // Configuration register indexes
  localparam logic CfgMinPad = 1'b0;
  localparam logic CfgMinLen = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] MinPadReset = 8'd8;
  localparam logic [7:0] MinLenReset = 8'd11;

  // Byte codes
  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [7:0] TypeOne   = 8'h01;
  localparam logic [7:0] TypeTwo   = 8'h02;
  localparam logic [7:0] CountMax  = 8'hFF;

  // Per-block parse state
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  pad_count;
    logic [7:0]  length_count;
    status_e     error_code;
    logic [1:0]  seen_type;
  } blk_state_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]  data_out;
    logic        data_valid;
    logic        done_res;
    status_e     status;
    logic [1:0]  block_type;
  } result_t;

  localparam blk_state_t BlkClear = '{
    phase:        PhFirst,
    pad_count:    8'd0,
    length_count: 8'd0,
    error_code:   StOk,
    seen_type:    2'd0
  };

endpackage

// ===== design/pkcsu_step.sv =====
// ----------------------------------------------------------------------------
// pkcsu_step: next-state and result logic for one byte
// Takes the current block state and one byte, gives the next state and the
// result transaction, if any, that the byte causes.
// ----------------------------------------------------------------------------
module pkcsu_step (
  input  pkcsu_pkg::blk_state_t state_i,
  input  logic [7:0]            byte_in_i,
  input  logic                  last_in_i,
  input  logic [7:0]            min_pad_bytes_i,
  input  logic [7:0]            min_length_i,
  output pkcsu_pkg::blk_state_t state_o,
  output pkcsu_pkg::result_t    result_o,
  output logic                  has_result_o
);

  pkcsu_pkg::blk_state_t upd;
  pkcsu_pkg::status_e    st;
  logic                  lead_zero;
  logic                  emit;

  // Phase update for this byte
  always_comb begin
    upd       = state_i;
    lead_zero = (state_i.phase == pkcsu_pkg::PhFirst) && (byte_in_i == pkcsu_pkg::ByteZero);
    emit      = 1'b0;
    if (lead_zero) begin
      upd.phase = pkcsu_pkg::PhType;
    end else begin
      if (state_i.length_count != pkcsu_pkg::CountMax) begin
        upd.length_count = state_i.length_count + 8'd1;
      end
      case (state_i.phase)
        pkcsu_pkg::PhFirst, pkcsu_pkg::PhType: begin
          if (byte_in_i == pkcsu_pkg::TypeOne || byte_in_i == pkcsu_pkg::TypeTwo) begin
            upd.seen_type = byte_in_i[1:0];
            upd.phase     = pkcsu_pkg::PhPad;
          end else begin
            upd.seen_type  = 2'd0;
            upd.error_code = pkcsu_pkg::StBadType;
            upd.phase      = pkcsu_pkg::PhDrain;
          end
        end
        pkcsu_pkg::PhPad: begin
          if (byte_in_i != pkcsu_pkg::ByteZero) begin
            if (state_i.pad_count != pkcsu_pkg::CountMax) begin
              upd.pad_count = state_i.pad_count + 8'd1;
            end
          end else begin
            if (state_i.pad_count < min_pad_bytes_i) begin
              upd.error_code = pkcsu_pkg::StShortPad;
            end
            upd.phase = pkcsu_pkg::PhData;
          end
        end
        pkcsu_pkg::PhData: begin
          emit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Final status, checks in priority order
  always_comb begin
    if (upd.length_count < min_length_i) begin
      st = pkcsu_pkg::StShort;
    end else if (upd.seen_type == 2'd0) begin
      st = pkcsu_pkg::StBadType;
    end else if (upd.phase != pkcsu_pkg::PhData) begin
      st = pkcsu_pkg::StNoSep;
    end else if (upd.error_code == pkcsu_pkg::StShortPad) begin
      st = pkcsu_pkg::StShortPad;
    end else begin
      st = pkcsu_pkg::StOk;
    end
  end

  // Result and block restart on the last byte
  always_comb begin
    result_o.data_out   = emit ? byte_in_i : 8'd0;
    result_o.data_valid = emit;
    result_o.done_res   = last_in_i;
    result_o.status     = last_in_i ? st : pkcsu_pkg::StOk;
    result_o.block_type = upd.seen_type;
    has_result_o        = emit | last_in_i;
    state_o             = last_in_i ? pkcsu_pkg::BlkClear : upd;
  end

endmodule

// ===== design/pkcs1_v15_block_unpad.sv =====
// ----------------------------------------------------------------------------
// pkcs1_v15_block_unpad: streaming PKCS#1 v1.5 padding remover
// Input register, one byte of parse logic, output register.
//
//   channel  | valid / stall            | payload
//   ---------+--------------------------+-------------------------------------
//   in       | in_valid_i / in_stall_o  | byte_in_i, last_in_i
//   out      | out_valid_o / out_stall_i| data_out_o, data_valid_o, done_res_o,
//            |                          | status_o, block_type_o
//   cfg      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while no stalled output holds the pipe; a
// byte's transaction is captured in the input register, and its result then
// in the output register, which presents it on the outputs.
// Reset clears the parse state, the valid flags and sets the thresholds to
// 8 padding bytes and 11 block bytes.
// A stalled output holds the pipe only when the waiting byte has a result;
// bytes with no result pass the parse stage regardless.
// ----------------------------------------------------------------------------
module pkcs1_v15_block_unpad (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       last_in_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o,
  output logic       data_valid_o,
  output logic       done_res_o,
  output logic [2:0] status_o,
  output logic [1:0] block_type_o
);

  logic [7:0]            min_pad_q;
  logic [7:0]            min_len_q;
  logic                  s1_valid_q, s1_valid_d;
  logic [7:0]            s1_byte_q;
  logic                  s1_last_q;
  pkcsu_pkg::blk_state_t state_q, state_d;
  pkcsu_pkg::result_t    res_d, res_q;
  logic                  has_res;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free, s1_proc, in_accept;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pad_q <= pkcsu_pkg::MinPadReset;
      min_len_q <= pkcsu_pkg::MinLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pkcsu_pkg::CfgMinPad: min_pad_q <= cfg_data_i;
        pkcsu_pkg::CfgMinLen: min_len_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Byte parse logic
  pkcsu_step u_step (
    .state_i         (state_q),
    .byte_in_i       (s1_byte_q),
    .last_in_i       (s1_last_q),
    .min_pad_bytes_i (min_pad_q),
    .min_length_i    (min_len_q),
    .state_o         (state_d),
    .result_o        (res_d),
    .has_result_o    (has_res)
  );

  // Handshake control
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_proc     = s1_valid_q && (!has_res || out_free);
  assign in_stall_o  = s1_valid_q && !s1_proc;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_proc);
  assign out_valid_d = (s1_proc && has_res) || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= pkcsu_pkg::BlkClear;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_proc) begin
        state_q <= state_d;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= byte_in_i;
      s1_last_q <= last_in_i;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (s1_proc && has_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = res_q.data_out;
  assign data_valid_o = res_q.data_valid;
  assign done_res_o   = res_q.done_res;
  assign status_o     = res_q.status;
  assign block_type_o = res_q.block_type;

endmodule

// ===== tb/tb_pkcs1_v15_block_unpad.sv =====
// ----------------------------------------------------------------------------
// tb_pkcs1_v15_block_unpad: self-checking bench for the block unpadder
// Drives padded blocks byte by byte through the valid/stall input channel,
// predicts every payload and status transaction with a behavioral parser
// kept in step with the thresholds written over the config port, and
// compares each output transaction in order. Directed blocks cover the
// status codes and counter saturation; random blocks, mostly well formed,
// run under several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module tb_pkcs1_v15_block_unpad;

  typedef logic [7:0] octet_q_t[$];

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] byte_in_i;
  logic       last_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_out_o;
  logic       data_valid_o;
  logic       done_res_o;
  logic [2:0] status_o;
  logic [1:0] block_type_o;

  // Predictor state and shadow copies of the thresholds
  pkcsu_pkg::blk_state_t parse_st;
  logic [7:0]            min_pad_cfg;
  logic [7:0]            min_len_cfg;
  pkcsu_pkg::result_t    pending_results[$];
  int unsigned           mismatch_cnt;
  int unsigned           idle_pct;
  int unsigned           stall_pct;

  pkcs1_v15_block_unpad dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .data_valid_o (data_valid_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o),
    .block_type_o (block_type_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #4000000;
    $display("tb_pkcs1_v15_block_unpad: done, errors");
    $finish;
  end

  // Receiver back-pressure, held low through reset
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Parse one accepted byte and queue the transaction it should produce
  task automatic predict_unpad(input logic [7:0] b, input logic lst);
    pkcsu_pkg::result_t res;
    logic               emit;
    pkcsu_pkg::status_e st;
    emit = 1'b0;
    st   = pkcsu_pkg::StOk;
    if (parse_st.phase == pkcsu_pkg::PhFirst && b == pkcsu_pkg::ByteZero) begin
      parse_st.phase = pkcsu_pkg::PhType;
    end else begin
      if (parse_st.length_count != pkcsu_pkg::CountMax) parse_st.length_count++;
      case (parse_st.phase)
        pkcsu_pkg::PhFirst, pkcsu_pkg::PhType: begin
          if (b == pkcsu_pkg::TypeOne || b == pkcsu_pkg::TypeTwo) begin
            parse_st.seen_type = b[1:0];
            parse_st.phase     = pkcsu_pkg::PhPad;
          end else begin
            parse_st.seen_type  = 2'd0;
            parse_st.error_code = pkcsu_pkg::StBadType;
            parse_st.phase      = pkcsu_pkg::PhDrain;
          end
        end
        pkcsu_pkg::PhPad: begin
          if (b != pkcsu_pkg::ByteZero) begin
            if (parse_st.pad_count != pkcsu_pkg::CountMax) parse_st.pad_count++;
          end else begin
            if (parse_st.pad_count < min_pad_cfg) begin
              parse_st.error_code = pkcsu_pkg::StShortPad;
            end
            parse_st.phase = pkcsu_pkg::PhData;
          end
        end
        pkcsu_pkg::PhData: begin
          emit = 1'b1;
        end
        default: ;
      endcase
    end
    // status priority: length, type, separator, padding
    if (lst) begin
      if (parse_st.length_count < min_len_cfg) st = pkcsu_pkg::StShort;
      else if (parse_st.seen_type == 2'd0) st = pkcsu_pkg::StBadType;
      else if (parse_st.phase != pkcsu_pkg::PhData) st = pkcsu_pkg::StNoSep;
      else if (parse_st.error_code == pkcsu_pkg::StShortPad) st = pkcsu_pkg::StShortPad;
      else st = pkcsu_pkg::StOk;
    end
    if (emit || lst) begin
      res.data_out   = emit ? b : 8'd0;
      res.data_valid = emit;
      res.done_res   = lst;
      res.status     = st;
      res.block_type = parse_st.seen_type;
      pending_results.push_back(res);
    end
    if (lst) parse_st = pkcsu_pkg::BlkClear;
  endtask

  // Output checker
  always @(posedge clk_i) begin
    pkcsu_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected transaction: data=%h dv=%b done=%b st=%0d bt=%0d",
                   data_out_o, data_valid_o, done_res_o, status_o, block_type_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data_out || data_valid_o !== want.data_valid ||
            done_res_o !== want.done_res || status_o !== want.status ||
            block_type_o !== want.block_type) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp data=%h dv=%b done=%b st=%0d bt=%0d",
                     want.data_out, want.data_valid, want.done_res, want.status,
                     want.block_type);
            $display("          got data=%h dv=%b done=%b st=%0d bt=%0d",
                     data_out_o, data_valid_o, done_res_o, status_o, block_type_o);
          end
        end
      end
    end
  end

  // One input transaction, with an optional random gap ahead of it
  task automatic send_octet(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    last_in_i  <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_unpad(b, lst);
  endtask

  task automatic send_block(input octet_q_t blk);
    foreach (blk[i]) send_octet(blk[i], i == blk.size() - 1);
  endtask

  // Let every expected transaction drain, then cover bytes still in flight
  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    settle_pipe();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == pkcsu_pkg::CfgMinPad) min_pad_cfg = val;
    else min_len_cfg = val;
  endtask

  // Random block: mostly well formed, some bad type, missing separator,
  // truncated, or plain noise
  function automatic octet_q_t make_block();
    octet_q_t    blk;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 6) begin
      n = $urandom_range(1, 6);
      repeat (n) blk.push_back(8'($urandom_range(255)));
      return blk;
    end
    if ($urandom_range(1)) blk.push_back(pkcsu_pkg::ByteZero);
    if (kind < 14) blk.push_back(8'($urandom_range(255)));
    else blk.push_back($urandom_range(1) ? pkcsu_pkg::TypeTwo : pkcsu_pkg::TypeOne);
    n = $urandom_range(0, 12);
    repeat (n) blk.push_back(8'($urandom_range(1, 255)));
    if (kind >= 22) blk.push_back(pkcsu_pkg::ByteZero);
    n = $urandom_range(0, 12);
    repeat (n) blk.push_back(8'($urandom_range(255)));
    if (kind >= 22 && kind < 30) begin
      n = $urandom_range(1, blk.size());
      while (blk.size() > n) void'(blk.pop_back());
    end
    return blk;
  endfunction

  task automatic pick_config();
    case ($urandom_range(7))
      0: begin
        write_cfg(pkcsu_pkg::CfgMinPad, 8'd0);
        write_cfg(pkcsu_pkg::CfgMinLen, 8'd0);
      end
      1: begin
        write_cfg(pkcsu_pkg::CfgMinPad, pkcsu_pkg::CountMax);
        write_cfg(pkcsu_pkg::CfgMinLen, 8'($urandom_range(0, 20)));
      end
      2: begin
        write_cfg(pkcsu_pkg::CfgMinPad, 8'($urandom_range(0, 10)));
        write_cfg(pkcsu_pkg::CfgMinLen, pkcsu_pkg::CountMax);
      end
      default: begin
        write_cfg(pkcsu_pkg::CfgMinPad, 8'($urandom_range(0, 10)));
        write_cfg(pkcsu_pkg::CfgMinLen, 8'($urandom_range(0, 24)));
      end
    endcase
  endtask

  // Reset thresholds: a one-byte block is too short
  task automatic test_too_short();
    octet_q_t blk;
    idle_pct  = 0;
    stall_pct = 0;
    blk = {pkcsu_pkg::TypeTwo};
    send_block(blk);
  endtask

  // Lone leading zero and bad block types, with the length check off
  task automatic test_bad_type();
    octet_q_t blk;
    write_cfg(pkcsu_pkg::CfgMinPad, 8'd2);
    write_cfg(pkcsu_pkg::CfgMinLen, 8'd0);
    blk = {pkcsu_pkg::ByteZero};
    send_block(blk);
    blk = {8'hFF};
    send_block(blk);
    blk = {pkcsu_pkg::ByteZero, 8'h03, pkcsu_pkg::ByteZero, 8'h55};
    send_block(blk);
  endtask

  // Good block with payload on the last byte, short padding, separator last
  task automatic test_payload_and_padding();
    octet_q_t blk;
    blk = {pkcsu_pkg::ByteZero, pkcsu_pkg::TypeTwo, 8'h11, 8'h22,
           pkcsu_pkg::ByteZero, 8'hAB, 8'hCD};
    send_block(blk);
    blk = {pkcsu_pkg::TypeOne, 8'h80, pkcsu_pkg::ByteZero, 8'h7F};
    send_block(blk);
    blk = {pkcsu_pkg::ByteZero, pkcsu_pkg::TypeOne, pkcsu_pkg::ByteZero};
    send_block(blk);
  endtask

  task automatic test_no_separator();
    octet_q_t blk;
    blk = {pkcsu_pkg::TypeTwo, 8'h05, 8'h06};
    send_block(blk);
  endtask

  // Extreme thresholds and saturating counters
  task automatic test_saturation();
    octet_q_t blk;
    write_cfg(pkcsu_pkg::CfgMinPad, pkcsu_pkg::CountMax);
    write_cfg(pkcsu_pkg::CfgMinLen, pkcsu_pkg::CountMax);
    blk = {pkcsu_pkg::ByteZero, pkcsu_pkg::TypeTwo};
    repeat (260) blk.push_back(8'($urandom_range(1, 255)));
    blk.push_back(pkcsu_pkg::ByteZero);
    repeat (3) blk.push_back(8'($urandom_range(255)));
    send_block(blk);
    write_cfg(pkcsu_pkg::CfgMinPad, 8'd0);
    write_cfg(pkcsu_pkg::CfgMinLen, 8'd0);
    blk = {pkcsu_pkg::TypeTwo, pkcsu_pkg::ByteZero};
    send_block(blk);
  endtask

  // Random blocks in groups, thresholds changed between groups
  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned budget);
    octet_q_t    blk;
    int unsigned sent;
    int unsigned grp;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < budget) begin
      pick_config();
      grp = 0;
      while (grp < 30) begin
        blk = make_block();
        send_block(blk);
        grp += blk.size();
      end
      sent += grp;
    end
    settle_pipe();
  endtask

  // Sequence
  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= 1'b0;
    cfg_data_i   <= 8'd0;
    in_valid_i   <= 1'b0;
    byte_in_i    <= 8'd0;
    last_in_i    <= 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    mismatch_cnt = 0;
    parse_st     = pkcsu_pkg::BlkClear;
    min_pad_cfg  = pkcsu_pkg::MinPadReset;
    min_len_cfg  = pkcsu_pkg::MinLenReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_too_short();
    test_bad_type();
    test_payload_and_padding();
    test_no_separator();
    test_saturation();
    test_random(0, 0, 100);
    test_random(55, 0, 100);
    test_random(0, 55, 100);
    test_random(13, 13, 100);

    settle_pipe();
    if (mismatch_cnt == 0) begin
      $display("tb_pkcs1_v15_block_unpad: done, clean");
    end else begin
      $display("tb_pkcs1_v15_block_unpad: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pkcsu_pkg.sv
design/pkcsu_step.sv
design/pkcs1_v15_block_unpad.sv
tb/tb_pkcs1_v15_block_unpad.sv
